// ===== rtl/core/tks_pkg.sv =====
package tks_pkg;

   localparam int unsigned ScoreWidth = 32;
   localparam int unsigned TopCountWidth = 4;
   localparam int unsigned TopCountReset = 5;

   typedef logic [ScoreWidth-1:0] score_type;

   // Ordering key: a larger key is a better score; every NaN maps to zero
   // and both zeros map to the same key.
   function automatic score_type order_key(input score_type bits);
      score_type mag;
      mag = {1'b0, bits[ScoreWidth-2:0]};
      if (mag > 32'h7F80_0000) begin
         order_key = '0;
      end else if (mag == '0) begin
         order_key = 32'h8000_0000;
      end else if (bits[ScoreWidth-1]) begin
         order_key = ~bits;
      end else begin
         order_key = bits | 32'h8000_0000;
      end
   endfunction

endpackage

// ===== rtl/core/tks_cell.sv =====
module tks_cell #(
   parameter int unsigned IdxWidth = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   clear,
   input  logic                   ins_en,
   input  tks_pkg::score_type     new_score,
   input  tks_pkg::score_type     new_key,
   input  logic [IdxWidth-1:0]    new_index,
   input  logic                   left_moves,
   input  logic                   left_valid,
   input  tks_pkg::score_type     left_score,
   input  logic [IdxWidth-1:0]    left_index,
   output logic                   moves,
   output logic                   valid,
   output tks_pkg::score_type     score,
   output logic [IdxWidth-1:0]    index
);

   logic                valid_ff;
   tks_pkg::score_type  score_ff;
   tks_pkg::score_type  key_ff;
   logic [IdxWidth-1:0] index_ff;

   // This cell is displaced when empty or strictly worse than the newcomer.
   assign moves = !valid_ff || (key_ff < new_key);
   assign valid = valid_ff;
   assign score = score_ff;
   assign index = index_ff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= 1'b0;
      end else if (ins_en && moves) begin
         valid_ff <= left_moves ? left_valid : 1'b1;
      end
      if (ins_en && moves) begin
         if (left_moves) begin
            score_ff <= left_score;
            key_ff   <= tks_pkg::order_key(left_score);
            index_ff <= left_index;
         end else begin
            score_ff <= new_score;
            key_ff   <= new_key;
            index_ff <= new_index;
         end
      end
   end

endmodule

// ===== rtl/core/top_k_score_selector_unit.sv =====
// Channel  | Direction | Contents
// req_     | in        | tdata = score[31:0]; tlast = last_score
// rsp_     | out       | tdata = rank[2:0], class_index[12:3], ranked_score[44:13],
//          |           |         zero fill; tuser = overflow; tlast = last_rank
// csr_     | in        | data = top_count[3:0]
// A score enters the insertion chain, one request a cycle while req_tready holds.
// A last request starts a report of one result a cycle from the chain while
// the output is free; no request is taken until the final result is delivered.
// Reset is synchronous, active high, and leaves the chain empty and
// top_count at five. Results wait in the output register under stall.
module top_k_score_selector_unit #(
   parameter int unsigned MAX_TOP = 8,
   parameter int unsigned MAX_CLASSES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // score
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // rank, class_index, ranked_score, zero fill
   output logic [0:0]  rsp_tuser,   // overflow
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_data     // top_count
);

   localparam int unsigned CntWidth = $clog2(MAX_CLASSES + 1);
   localparam int unsigned PosWidth = (MAX_TOP > 1) ? $clog2(MAX_TOP) : 1;
   localparam int unsigned IdxWidth = 10;

   typedef enum logic {ST_RANK, ST_REPORT} state_type;

   state_type           state_ff;
   logic [3:0]          top_count_ff;
   logic [CntWidth-1:0] count_ff;
   logic                ovf_ff;
   logic [PosWidth-1:0] pos_ff;
   logic                out_valid_ff;
   logic [47:0]         out_data_ff;
   logic                out_ovf_ff;
   logic                out_last_ff;

   logic                 accept;
   logic                 rank_it;
   logic                 clear;
   tks_pkg::score_type   new_key;
   logic [IdxWidth-1:0]  new_index;
   logic [MAX_TOP:0]     mv;
   logic [MAX_TOP:0]     vl;
   tks_pkg::score_type   sc [MAX_TOP+1];
   logic [IdxWidth-1:0]  ix [MAX_TOP+1];
   logic [PosWidth:0]    want;
   logic [PosWidth:0]    have_in;
   logic [PosWidth:0]    rd_sel;
   logic                 out_free;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_RANK) && !out_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign rank_it    = accept && (count_ff < CntWidth'(MAX_CLASSES));
   assign new_key    = tks_pkg::order_key(req_tdata);
   assign new_index  = IdxWidth'(count_ff);
   assign out_free   = !out_valid_ff || rsp_tready;

   // The chain head: a virtual left neighbour that never moves.
   assign mv[0] = 1'b0;
   assign vl[0] = 1'b0;
   assign sc[0] = '0;
   assign ix[0] = '0;

   for (genvar g = 0; g < MAX_TOP; g++) begin : g_cell
      tks_cell #(.IdxWidth(IdxWidth)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .clear     (clear),
         .ins_en    (rank_it),
         .new_score (req_tdata),
         .new_key   (new_key),
         .new_index (new_index),
         .left_moves(mv[g]),
         .left_valid(vl[g]),
         .left_score(sc[g]),
         .left_index(ix[g]),
         .moves     (mv[g+1]),
         .valid     (vl[g+1]),
         .score     (sc[g+1]),
         .index     (ix[g+1])
      );
   end

   // Reported entries: clamped top_count, limited by the filled cells.
   // The chain does not change during a report, but a top_count write during
   // a report still changes this count between the first result and the last.
   always_comb begin
      if (top_count_ff == '0) begin
         want = (PosWidth+1)'(1);
      end else if (32'(top_count_ff) > MAX_TOP) begin
         want = (PosWidth+1)'(MAX_TOP);
      end else begin
         want = (PosWidth+1)'(top_count_ff);
      end
      have_in = '0;
      for (int i = 0; i < MAX_TOP; i++) begin
         if (vl[i+1] && (32'(i) < 32'(want))) begin
            have_in = (PosWidth+1)'(i + 1);
         end
      end
   end

   // Cell number of the entry at the current rank; cell zero is the head.
   assign rd_sel = {1'b0, pos_ff} + 1'b1;

   assign clear = (state_ff == ST_REPORT) && out_free && (rd_sel == have_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RANK;
         top_count_ff <= 4'(tks_pkg::TopCountReset);
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            top_count_ff <= csr_data;
         end
         if (out_valid_ff && rsp_tready && (state_ff != ST_REPORT)) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_RANK: begin
               if (accept) begin
                  if (rank_it) begin
                     count_ff <= count_ff + 1'b1;
                  end else begin
                     ovf_ff <= 1'b1;
                  end
                  if (req_tlast) begin
                     state_ff <= ST_REPORT;
                     pos_ff   <= '0;
                  end
               end
            end
            ST_REPORT: begin
               if (out_free) begin
                  out_valid_ff <= 1'b1;
                  out_data_ff  <= {3'b000, sc[rd_sel], ix[rd_sel], 3'(pos_ff)};
                  out_ovf_ff   <= ovf_ff;
                  out_last_ff  <= clear;
                  pos_ff       <= pos_ff + 1'b1;
                  if (clear) begin
                     state_ff <= ST_RANK;
                     count_ff <= '0;
                     ovf_ff   <= 1'b0;
                  end
               end
            end
            default: state_ff <= ST_RANK;
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_ovf_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
